// File: rtl/core/dfs_topological_sort_top_macros.svh
// Assertion macros used by the topological sort search sequencer.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef DFS_TOPOLOGICAL_SORT_TOP_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dfs_ts_pkg.sv
// Shared types and constants for the depth-first topological sort.
// No dependencies; used by every module of the block.
package dfs_ts_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 256;
  localparam int VTX_W         = 7;
  localparam logic [VTX_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_RUN = 1'b1;

  typedef logic [VTX_W-1:0] vtx_t;

  // Requests from the search sequencer to the edge store.
  typedef struct packed {
    logic node_rd;
    logic edge_rd;
    logic clear;
  } graph_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_LOAD,
    S_TOP,
    S_POP,
    S_EDGE,
    S_MARK,
    S_EMIT_RD,
    S_EMIT_WR,
    S_CYCLE
  } srch_state_t;

endpackage

// File: rtl/core/dfs_ts_graph.sv
// Edge store: per-vertex adjacency lists kept in arrival order in synchronous memories.
// Depends on dfs_ts_pkg.
module dfs_ts_graph #(
  parameter int MAX_NODES = dfs_ts_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dfs_ts_pkg::DEF_MAX_EDGES,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int EPW = $clog2(MAX_EDGES + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   add_en,
  input  dfs_ts_pkg::vtx_t       add_src,
  input  dfs_ts_pkg::vtx_t       add_dst,
  input  dfs_ts_pkg::graph_req_t req,
  input  logic [NW-1:0]          node_addr,
  input  logic [EW-1:0]          edge_addr,
  output logic                   head_vld,
  output logic [EW-1:0]          head_edge,
  output logic [EW-1:0]          tail_edge,
  output logic [NW-1:0]          edge_target,
  output logic [EW-1:0]          edge_link,
  output logic                   overflow
);
  import dfs_ts_pkg::*;

  logic [NW-1:0] tgt_mem  [MAX_EDGES];
  logic [EW-1:0] link_mem [MAX_EDGES];
  logic [EW-1:0] head_mem [MAX_NODES];
  logic [EW-1:0] tail_mem [MAX_NODES];

  logic [MAX_NODES-1:0] head_valid;
  logic [EPW-1:0]       edge_total;
  logic                 patch_en;
  logic [EW-1:0]        patch_edge;

  logic          src_ok, dst_ok, full, do_add, set_ovf;
  logic [NW-1:0] src_idx, dst_idx, tail_addr;
  logic [EW-1:0] new_edge;

  assign src_ok   = (add_src != '0) && (add_src <= VTX_W'(MAX_NODES));
  assign dst_ok   = (add_dst != '0) && (add_dst <= VTX_W'(MAX_NODES));
  assign full     = (edge_total == EPW'(MAX_EDGES));
  assign do_add   = add_en && src_ok && dst_ok && !full;
  assign set_ovf  = add_en && src_ok && dst_ok && full;
  assign src_idx  = NW'(add_src - VTX_W'(1));
  assign dst_idx  = NW'(add_dst - VTX_W'(1));
  assign new_edge = edge_total[EW-1:0];
  assign tail_addr = do_add ? src_idx : node_addr;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      edge_total <= '0;
      overflow   <= 1'b0;
      patch_en   <= 1'b0;
    end else begin
      patch_en <= do_add && head_valid[src_idx];
      if (req.clear) begin
        head_valid <= '0;
        edge_total <= '0;
        overflow   <= 1'b0;
      end else begin
        if (do_add) begin
          head_valid[src_idx] <= 1'b1;
          edge_total          <= edge_total + EPW'(1);
        end
        if (set_ovf) overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) patch_edge <= new_edge;
    if (req.node_rd) head_vld <= head_valid[node_addr];
  end

  // Target memory.
  always_ff @(posedge clk) begin
    if (do_add) tgt_mem[new_edge] <= dst_idx;
    if (req.edge_rd) edge_target <= tgt_mem[edge_addr];
  end

  // Link memory: the old tail read at add time is patched in the next cycle.
  always_ff @(posedge clk) begin
    if (patch_en) link_mem[tail_edge] <= patch_edge;
    if (req.edge_rd) edge_link <= link_mem[edge_addr];
  end

  always_ff @(posedge clk) begin
    if (do_add && !head_valid[src_idx]) head_mem[src_idx] <= new_edge;
    if (req.node_rd) head_edge <= head_mem[node_addr];
  end

  always_ff @(posedge clk) begin
    if (do_add) tail_mem[src_idx] <= new_edge;
    if (do_add || req.node_rd) tail_edge <= tail_mem[tail_addr];
  end

endmodule

// File: rtl/core/dfs_ts_search.sv
// Depth-first search sequencer with walk stack, visit marks, finish order and result register.
// Depends on dfs_ts_pkg and dfs_topological_sort_top_macros.svh.
`include "dfs_topological_sort_top_macros.svh"
module dfs_ts_search #(
  parameter int MAX_NODES = dfs_ts_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dfs_ts_pkg::DEF_MAX_EDGES,
  localparam int NW = $clog2(MAX_NODES),
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NW:0]            n_eff,
  input  logic                   dropped_in,
  output logic                   busy,
  output dfs_ts_pkg::graph_req_t req,
  output logic [NW-1:0]          node_addr,
  output logic [EW-1:0]          edge_addr,
  input  logic                   head_vld,
  input  logic [EW-1:0]          head_edge,
  input  logic [EW-1:0]          tail_edge,
  input  logic [NW-1:0]          edge_target,
  input  logic [EW-1:0]          edge_link,
  output logic                   out_valid,
  input  logic                   out_stall,
  output dfs_ts_pkg::vtx_t       vertex,
  output logic                   cycle_found,
  output logic                   edges_dropped,
  output logic                   last
);
  import dfs_ts_pkg::*;

  typedef struct packed {
    logic [NW-1:0] node;
    logic [EW-1:0] edge_ptr;
    logic [EW-1:0] tail;
    logic          has;
  } frame_t;

  frame_t        stack_mem [MAX_NODES];
  logic          done_mem  [MAX_NODES];
  logic [NW-1:0] order_mem [MAX_NODES];

  srch_state_t state, state_next;
  logic [NW:0]   n_q, root, sp, fc;
  logic [NW-1:0] ld_node, idx;
  logic          dropped_q;
  frame_t        top, stack_q;
  logic          done_q;
  logic [NW-1:0] order_q;
  logic [MAX_NODES-1:0] visit_valid;

  logic          out_free, tgt_in, visited, is_open;
  logic [NW-1:0] root_idx;

  // Memory port controls.
  logic          stk_we, stk_re, done_we, done_val, done_re, ord_we, ord_re, mark_set;
  logic [NW-1:0] stk_waddr, stk_raddr, done_addr, mark_addr;

  assign root_idx = root[NW-1:0];
  assign out_free = !out_valid || !out_stall;
  assign tgt_in   = {1'b0, edge_target} < n_q;
  assign visited  = visit_valid[edge_target];
  assign is_open  = visited && !done_q;
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_ROOT;
      S_ROOT: begin
        if (root == n_q) state_next = S_EMIT_RD;
        else if (!visit_valid[root_idx]) state_next = S_LOAD;
      end
      S_LOAD:    state_next = S_TOP;
      S_TOP: begin
        if (top.has) state_next = S_EDGE;
        else if (sp == (NW+1)'(1)) state_next = S_ROOT;
        else state_next = S_POP;
      end
      S_POP:     state_next = S_TOP;
      S_EDGE:    state_next = tgt_in ? S_MARK : S_TOP;
      S_MARK: begin
        if (is_open) state_next = S_CYCLE;
        else if (!visited) state_next = S_LOAD;
        else state_next = S_TOP;
      end
      S_EMIT_RD: state_next = S_EMIT_WR;
      S_EMIT_WR: begin
        if (out_free) state_next = (idx == '0) ? S_IDLE : S_EMIT_RD;
      end
      S_CYCLE:   if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req       = '0;
    node_addr = root_idx;
    edge_addr = top.edge_ptr;
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_waddr = NW'(sp - (NW+1)'(1));
    stk_raddr = NW'(sp - (NW+1)'(2));
    done_we   = 1'b0;
    done_val  = 1'b0;
    done_re   = 1'b0;
    done_addr = top.node;
    ord_we    = 1'b0;
    ord_re    = 1'b0;
    mark_set  = 1'b0;
    mark_addr = root_idx;
    unique case (state)
      S_ROOT: begin
        if (root != n_q && !visit_valid[root_idx]) begin
          req.node_rd = 1'b1;
          mark_set    = 1'b1;
          done_we     = 1'b1;
          done_addr   = root_idx;
        end
      end
      S_TOP: begin
        if (top.has) begin
          req.edge_rd = 1'b1;
        end else begin
          done_we  = 1'b1;
          done_val = 1'b1;
          ord_we   = (fc != (NW+1)'(MAX_NODES));
          stk_re   = (sp != (NW+1)'(1));
        end
      end
      S_EDGE: begin
        done_re   = tgt_in;
        done_addr = edge_target;
      end
      S_MARK: begin
        if (!visited) begin
          stk_we      = 1'b1;
          req.node_rd = 1'b1;
          node_addr   = edge_target;
          mark_set    = 1'b1;
          mark_addr   = edge_target;
          done_we     = 1'b1;
          done_addr   = edge_target;
        end
      end
      S_EMIT_RD: ord_re = 1'b1;
      S_EMIT_WR: req.clear = out_free && (idx == '0);
      S_CYCLE:   req.clear = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Sequencer registers and visit bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      visit_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (req.clear) visit_valid <= '0;
      else if (mark_set) visit_valid[mark_addr] <= 1'b1;
      if (req.clear || (state == S_EMIT_WR && out_free)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          n_q       <= n_eff;
          dropped_q <= dropped_in;
          root      <= '0;
          sp        <= '0;
          fc        <= '0;
        end
      end
      S_ROOT: begin
        if (root != n_q && !visit_valid[root_idx]) begin
          ld_node <= root_idx;
          sp      <= (NW+1)'(1);
        end else if (root != n_q) begin
          root <= root + (NW+1)'(1);
        end
        idx <= NW'(fc - (NW+1)'(1));
      end
      S_LOAD: begin
        top.node     <= ld_node;
        top.has      <= head_vld;
        top.edge_ptr <= head_edge;
        top.tail     <= tail_edge;
      end
      S_TOP: begin
        if (!top.has) begin
          if (fc != (NW+1)'(MAX_NODES)) fc <= fc + (NW+1)'(1);
          sp <= sp - (NW+1)'(1);
          if (sp == (NW+1)'(1)) root <= root + (NW+1)'(1);
        end
      end
      S_POP: top <= stack_q;
      S_EDGE: begin
        top.has      <= (top.edge_ptr != top.tail);
        top.edge_ptr <= edge_link;
      end
      S_MARK: begin
        if (!visited) begin
          ld_node <= edge_target;
          sp      <= sp + (NW+1)'(1);
        end
      end
      S_EMIT_WR: begin
        if (out_free) begin
          vertex        <= VTX_W'(order_q) + VTX_W'(1);
          cycle_found   <= 1'b0;
          edges_dropped <= dropped_q;
          last          <= (idx == '0);
          idx           <= idx - NW'(1);
        end
      end
      S_CYCLE: begin
        if (out_free) begin
          vertex        <= '0;
          cycle_found   <= 1'b1;
          edges_dropped <= dropped_q;
          last          <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Walk stack memory; the top frame lives in registers.
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= top;
    if (stk_re) stack_q <= stack_mem[stk_raddr];
  end

  // Finished bit per vertex; meaningful only where the visit bit is set.
  always_ff @(posedge clk) begin
    if (done_we) done_mem[done_addr] <= done_val;
    if (done_re) done_q <= done_mem[done_addr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) order_mem[fc[NW-1:0]] <= top.node;
    if (ord_re) order_q <= order_mem[idx];
  end

  `DFS_ASSERT_NOW(a_cycle_form, out_valid && cycle_found, last && (vertex == '0), "cycle result malformed")
  `DFS_ASSERT_NOW(a_top_nonempty, state == S_TOP, sp != '0, "search frame missing")
  `DFS_ASSERT_NOW(a_fc_bound, state != S_IDLE && state != S_ROOT, fc <= n_q, "finish count beyond vertices")
  `DFS_ASSERT_NEXT(a_clear_idle, req.clear, state == S_IDLE && out_valid, "run did not close")

endmodule

// File: rtl/core/dfs_topological_sort_top.sv
// Top level of the depth-first topological sort with cycle detection.
// Depends on dfs_ts_pkg, dfs_ts_graph and dfs_ts_search.
//
//   Channel   Handshake                   Payload
//   -------   -------------------------   ------------------------------------------
//   config    cfg_wen                     cfg_wdata (node_count)
//   input     in_valid / in_stall         cmd, src_vertex, dst_vertex
//   output    out_valid / out_stall       vertex, cycle_found, edges_dropped, last
//
// Edge items may arrive back to back; the source list's tail is read at accept time and
// the old tail's link is patched in the next cycle. A run item holds in_stall high while
// it scans the roots, walks each vertex reached and its edges, and then emits one result
// per finished vertex; a back edge ends it with one result.
// Reset sets node_count to 64 and empties the graph; each run clears it again at its end.
// A stalled result holds the output register, and the next result waits behind it.
module dfs_topological_sort_top #(
  parameter int MAX_NODES = dfs_ts_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dfs_ts_pkg::DEF_MAX_EDGES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  dfs_ts_pkg::vtx_t cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cmd,
  input  dfs_ts_pkg::vtx_t src_vertex,
  input  dfs_ts_pkg::vtx_t dst_vertex,
  output logic             out_valid,
  input  logic             out_stall,
  output dfs_ts_pkg::vtx_t vertex,
  output logic             cycle_found,
  output logic             edges_dropped,
  output logic             last
);
  import dfs_ts_pkg::*;

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  vtx_t          node_count;
  logic [NW:0]   n_eff;
  logic          accept, busy, overflow;
  graph_req_t    req;
  logic [NW-1:0] node_addr, edge_target;
  logic [EW-1:0] edge_addr, head_edge, tail_edge, edge_link;
  logic          head_vld;

  // Node count; the user writes it only while the block is idle; not enforced here.
  always_ff @(posedge clk) begin
    if (rst) node_count <= NODE_COUNT_RST;
    else if (cfg_wen) node_count <= cfg_wdata;
  end

  // Zero counts as one vertex and anything above the capacity as the capacity.
  always_comb begin
    if (node_count == '0) n_eff = (NW+1)'(1);
    else if (node_count > VTX_W'(MAX_NODES)) n_eff = (NW+1)'(MAX_NODES);
    else n_eff = (NW+1)'(node_count);
  end

  // Items are refused for the whole of a run.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  dfs_ts_graph #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_graph (
    .clk        (clk),
    .rst        (rst),
    .add_en     (accept && (cmd == CMD_ADD)),
    .add_src    (src_vertex),
    .add_dst    (dst_vertex),
    .req        (req),
    .node_addr  (node_addr),
    .edge_addr  (edge_addr),
    .head_vld   (head_vld),
    .head_edge  (head_edge),
    .tail_edge  (tail_edge),
    .edge_target(edge_target),
    .edge_link  (edge_link),
    .overflow   (overflow)
  );

  dfs_ts_search #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_search (
    .clk          (clk),
    .rst          (rst),
    .start        (accept && (cmd == CMD_RUN)),
    .n_eff        (n_eff),
    .dropped_in   (overflow),
    .busy         (busy),
    .req          (req),
    .node_addr    (node_addr),
    .edge_addr    (edge_addr),
    .head_vld     (head_vld),
    .head_edge    (head_edge),
    .tail_edge    (tail_edge),
    .edge_target  (edge_target),
    .edge_link    (edge_link),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex       (vertex),
    .cycle_found  (cycle_found),
    .edges_dropped(edges_dropped),
    .last         (last)
  );

endmodule
